@@ design/cdq_pkg.sv @@
`timescale 1ns / 1ps
// Package for the circular deque: sizes, operation codes and the
// command struct passed from controller to datapath. No dependencies.
package cdq_pkg;

    localparam int SLOTS      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_BITS    = 2;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 4;

    typedef logic [OP_BITS-1:0]    op_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    localparam op_t OP_PUSH_BACK  = 2'd0;
    localparam op_t OP_PUSH_FRONT = 2'd1;
    localparam op_t OP_POP_FRONT  = 2'd2;
    localparam op_t OP_POP_BACK   = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } cdq_cmd_t;

    function automatic idx_t wrap_next(input idx_t i);
        idx_t r;
        if (i == idx_t'(SLOTS - 1))
            r = '0;
        else
            r = i + idx_t'(1);
        return r;
    endfunction

    function automatic idx_t wrap_prev(input idx_t i);
        idx_t r;
        if (i == '0)
            r = idx_t'(SLOTS - 1);
        else
            r = i - idx_t'(1);
        return r;
    endfunction

endpackage

@@ design/cdq_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the circular deque: valid/ready plus one request beat.
// Depends on cdq_pkg.
interface cdq_req_if import cdq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [DATA_BITS-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

@@ design/cdq_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the circular deque: valid/ready plus one result beat.
// Depends on cdq_pkg.
interface cdq_rsp_if import cdq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [DATA_BITS-1:0]  popped_value;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
    logic                  is_full;

    modport source (output valid, output accepted, output popped_value, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input popped_value, input count,
                    input is_empty, input is_full, output ready);
endinterface

@@ design/circular_deque.sv @@
`timescale 1ns / 1ps
// Circular deque top level: request and response channels around controller
// and datapath. Depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl, cdq_dpath.
//
// Usage:
//   req carries one request beat: op (push back, push front, pop front,
//   pop back) and push_value. rsp returns one result beat per request:
//   accepted, popped_value, count, is_empty and is_full.
//   A push to a full deque or a pop from an empty one comes back with
//   accepted low and leaves the contents unchanged.
//   The ring holds SLOTS-1 values; one slot always stays unused.
// Sequencing:
//   Once the request beat is taken, the controller passes through EXEC,
//   where the pointers update and the ring RAM does its registered read at
//   the same edge, and then to RESP, where the result beat is valid.
//   Requests are served one at a time, the next only after rsp takes the result.
// Reset:
//   rst_n clears head and tail, leaving the deque empty and idle. The ring
//   contents are not cleared; only written entries are ever read back.
// Stall:
//   While rsp.ready is low the result beat holds and req.ready stays low.
module circular_deque import cdq_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    cdq_req_if.sink  req,
    cdq_rsp_if.source rsp
);

    cdq_cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cdq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (req.op),
        .push_value   (req.push_value),
        .accepted     (rsp.accepted),
        .popped_value (rsp.popped_value),
        .count        (rsp.count),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full)
    );

endmodule

@@ design/cdq_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/cdq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the circular deque: sequences accept, execute and respond.
// Depends on cdq_pkg.
module cdq_ctrl import cdq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output cdq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.exec  = (state_reg == ST_EXEC);

endmodule

@@ design/cdq_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the circular deque: head/tail pointers, ring storage, result fields.
// Depends on cdq_pkg and cdq_ram.
module cdq_dpath import cdq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_cmd_t              cmd,
    input  op_t                   op,
    input  logic [DATA_BITS-1:0]  push_value,
    output logic                  accepted,
    output logic [DATA_BITS-1:0]  popped_value,
    output logic [COUNT_BITS-1:0] count,
    output logic                  is_empty,
    output logic                  is_full
);

    op_t    op_reg;
    value_t value_reg;
    idx_t   head_reg;
    idx_t   head_next;
    idx_t   tail_reg;
    idx_t   tail_next;
    logic   ok_reg;
    logic   ok_next;
    logic   pop_reg;
    logic   pop_next;

    logic   empty;
    logic   full;
    logic   ram_we;
    idx_t   ram_waddr;
    idx_t   ram_raddr;
    value_t ram_rdata;
    logic [IDX_BITS:0] count_full;

    assign empty = (head_reg == tail_reg);
    assign full  = (wrap_next(tail_reg) == head_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        ok_next   = ok_reg;
        pop_next  = pop_reg;
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_raddr = head_reg;
        unique case (op_reg)
            OP_PUSH_BACK:
            begin
                ram_waddr = tail_reg;
                if (cmd.exec && !full)
                begin
                    ram_we    = 1'b1;
                    tail_next = wrap_next(tail_reg);
                end
            end
            OP_PUSH_FRONT:
            begin
                ram_waddr = wrap_prev(head_reg);
                if (cmd.exec && !full)
                begin
                    ram_we    = 1'b1;
                    head_next = wrap_prev(head_reg);
                end
            end
            OP_POP_FRONT:
            begin
                ram_raddr = head_reg;
                if (cmd.exec && !empty)
                    head_next = wrap_next(head_reg);
            end
            OP_POP_BACK:
            begin
                ram_raddr = wrap_prev(tail_reg);
                if (cmd.exec && !empty)
                    tail_next = wrap_prev(tail_reg);
            end
            default:
            begin
                ram_raddr = head_reg;
            end
        endcase
        if (cmd.exec)
        begin
            pop_next = op_reg[1];
            ok_next  = op_reg[1] ? !empty : !full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            ok_reg   <= 1'b0;
            pop_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ok_reg   <= ok_next;
            pop_reg  <= pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= VALUE_BITS'(push_value);
        end
    end

    cdq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (cmd.exec),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (tail_reg >= head_reg)
            count_full = {1'b0, tail_reg} - {1'b0, head_reg};
        else
            count_full = {1'b0, tail_reg} + (IDX_BITS+1)'(SLOTS) - {1'b0, head_reg};
    end

    assign accepted     = ok_reg;
    assign popped_value = (ok_reg && pop_reg) ? DATA_BITS'(ram_rdata) : '0;
    assign count        = COUNT_BITS'(count_full);
    assign is_empty     = empty;
    assign is_full      = full;

endmodule
